// ===== src/assert_macros.svh =====
// Assertion macros shared by the reorder commit buffer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== src/rcb_pkg.sv =====
// Package for the reorder commit buffer: field structs, result kinds, defaults.
// Depends on nothing.
package rcb_pkg;
	localparam int DefBufferDepth = 32;
	localparam int DefNumPhysTags = 128;
	localparam logic       CMD_PUSH = 1'b0;
	localparam logic       CMD_WB   = 1'b1;
	localparam logic [1:0] KIND_COMMIT = 2'd0;
	localparam logic [1:0] KIND_NOMATCH = 2'd1;
	localparam logic [1:0] KIND_FULL = 2'd2;
	typedef struct packed {
		logic        command;
		logic [1:0]  priv_mode;
		logic [63:0] pc;
		logic [31:0] instruction;
		logic        has_dest;
		logic        dest_is_float;
		logic [4:0]  dest_reg;
		logic        partial;
		logic [6:0]  phys_tag;
		logic [63:0] data;
	} cmd_t;
	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  out_priv_mode;
		logic [63:0] out_pc;
		logic [31:0] out_instruction;
		logic        out_has_dest;
		logic        out_dest_is_float;
		logic [4:0]  out_dest_reg;
		logic [63:0] out_data;
		logic        last;
	} res_t;
	typedef struct packed {
		logic [1:0]  priv_mode;
		logic        has_dest;
		logic        dest_is_float;
		logic [4:0]  dest_reg;
		logic [63:0] pc;
		logic [31:0] instruction;
	} ent_t;
endpackage

// ===== src/reorder_commit_buffer_core.sv =====
// Top level of the reorder commit buffer: control, pointers and result register.
// Depends on rcb_pkg, rcb_store, rcb_tags and assert_macros.svh.
//  channel  | signals              | transfer
//  command  | start, busy, cmd     | start && !busy at clk rise
//  result   | res_valid, res       | one cycle each, no stall
// A push or writeback is accepted and registered, then one memory read per entry drained
// and a closing step back to idle; the drain rate is set by the single read port.
// Error results pass through ST_ERR and the output register. Reset clears pointers and flags.
// The receiver cannot stall, so results leave one per cycle from the output register.
`include "assert_macros.svh"
module reorder_commit_buffer_core import rcb_pkg::*; #(
	parameter int BufferDepth = DefBufferDepth,
	localparam int Aw = $clog2(BufferDepth)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic res_valid,
	output res_t res
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DRAIN = 2'd1;
	localparam logic [1:0] ST_ERR = 2'd2;
	localparam logic [Aw:0] Full = (Aw+1)'(BufferDepth);
	logic [1:0] state_q;
	logic [Aw-1:0] head_q, tail_q;
	logic [Aw:0] occ_q;
	logic [1:0] err_q;
	logic rd_pend_q;
	logic [Aw-1:0] rd_idx;
	logic hit;
	logic [Aw-1:0] hit_idx;
	logic [BufferDepth-1:0] waiting;
	ent_t ent_r;
	logic [63:0] dat_r;
	logic acc, push_ok, wb_ok;
	logic can_pop;
	logic [Aw:0] occ_after;
	logic [Aw-1:0] head_nx;
	ent_t ent_w;
	res_t res_d;
	assign acc = start && !busy;
	assign push_ok = acc && cmd.command == CMD_PUSH && occ_q != Full;
	assign wb_ok = acc && cmd.command == CMD_WB && hit;
	assign busy = state_q != ST_IDLE;
	assign head_nx = (head_q == Aw'(BufferDepth - 1)) ? '0 : head_q + Aw'(1);
	assign occ_after = occ_q - (Aw+1)'(rd_pend_q);
	assign can_pop = occ_after != '0 && !waiting[rd_idx];
	assign rd_idx = rd_pend_q ? head_nx : head_q;
	assign ent_w = '{cmd.priv_mode, cmd.has_dest, cmd.dest_is_float, cmd.dest_reg,
		cmd.pc, cmd.instruction};
	rcb_store #(.BufferDepth(BufferDepth)) u_store (
		.clk(clk), .ent_we(push_ok), .ent_waddr(tail_q), .ent_wdata(ent_w),
		.dat_we(push_ok || wb_ok), .dat_waddr(push_ok ? tail_q : hit_idx),
		.dat_wdata((push_ok && cmd.partial) ? 64'd0 : cmd.data),
		.raddr(rd_idx), .ent_rdata(ent_r), .dat_rdata(dat_r)
	);
	rcb_tags #(.BufferDepth(BufferDepth)) u_tags (
		.clk(clk), .arst_n(arst_n), .set_en(push_ok), .set_idx(tail_q),
		.set_wait(cmd.partial), .set_tag(cmd.phys_tag), .clr_en(wb_ok), .clr_idx(hit_idx),
		.srch_tag(cmd.phys_tag), .head(head_q), .hit(hit), .hit_idx(hit_idx),
		.waiting(waiting)
	);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			tail_q <= '0;
			occ_q <= '0;
			rd_pend_q <= 1'b0;
			err_q <= KIND_COMMIT;
			res_valid <= 1'b0;
		end else begin
			res_valid <= (state_q == ST_ERR) || (state_q == ST_DRAIN && rd_pend_q);
			unique case (state_q)
				ST_IDLE: begin
					rd_pend_q <= 1'b0;
					if (push_ok) begin
						tail_q <= (tail_q == Aw'(BufferDepth - 1)) ? '0 : tail_q + Aw'(1);
						occ_q <= occ_q + (Aw+1)'(1);
						state_q <= ST_DRAIN;
					end else if (wb_ok) begin
						state_q <= ST_DRAIN;
					end else if (acc) begin
						err_q <= (cmd.command == CMD_PUSH) ? KIND_FULL : KIND_NOMATCH;
						state_q <= ST_ERR;
					end
				end
				ST_DRAIN: begin
					if (rd_pend_q) begin
						head_q <= head_nx;
						occ_q <= occ_after;
					end
					rd_pend_q <= can_pop;
					if (!can_pop) state_q <= ST_IDLE;
				end
				ST_ERR: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
	always_comb begin
		res_d = '0;
		if (state_q == ST_ERR) begin
			res_d.kind = err_q;
			res_d.last = 1'b1;
		end else begin
			res_d.kind = KIND_COMMIT;
			res_d.out_priv_mode = ent_r.priv_mode;
			res_d.out_pc = ent_r.pc;
			res_d.out_instruction = ent_r.instruction;
			res_d.out_has_dest = ent_r.has_dest;
			res_d.out_dest_is_float = ent_r.has_dest & ent_r.dest_is_float;
			res_d.out_dest_reg = ent_r.has_dest ? ent_r.dest_reg : 5'd0;
			res_d.out_data = ent_r.has_dest ? dat_r : 64'd0;
			res_d.last = !can_pop;
		end
	end
	always_ff @(posedge clk) begin
		res <= res_d;
	end
	`ASSERT_CLK(a_occ_bound, clk, arst_n, occ_q <= Full, "occupancy beyond depth")
	`ASSERT_CLK(a_no_acc_busy, clk, arst_n, busy |-> !acc, "transfer while busy")
	`ASSERT_CLK(a_err_one, clk, arst_n, state_q == ST_ERR |=> res_valid && state_q == ST_IDLE,
		"error result not single")
	`ASSERT_CLK(a_pop_nonempty, clk, arst_n, (state_q == ST_DRAIN && rd_pend_q) |-> occ_q != '0,
		"drain from empty buffer")
endmodule

// ===== src/rcb_store.sv =====
// Entry memories of the reorder commit buffer: payload and data, one write, one read.
// Depends on rcb_pkg.
module rcb_store import rcb_pkg::*; #(
	parameter int BufferDepth = DefBufferDepth,
	localparam int Aw = $clog2(BufferDepth)
) (
	input  logic          clk,
	input  logic          ent_we,
	input  logic [Aw-1:0] ent_waddr,
	input  ent_t          ent_wdata,
	input  logic          dat_we,
	input  logic [Aw-1:0] dat_waddr,
	input  logic [63:0]   dat_wdata,
	input  logic [Aw-1:0] raddr,
	output ent_t          ent_rdata,
	output logic [63:0]   dat_rdata
);
	ent_t        ent_mem [BufferDepth];
	logic [63:0] dat_mem [BufferDepth];
	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
		if (dat_we) dat_mem[dat_waddr] <= dat_wdata;
		ent_rdata <= ent_mem[raddr];
		dat_rdata <= dat_mem[raddr];
	end
endmodule

// ===== src/rcb_tags.sv =====
// Tag and waiting flags per entry with oldest-match search from the head.
// Depends on rcb_pkg.
module rcb_tags import rcb_pkg::*; #(
	parameter int BufferDepth = DefBufferDepth,
	localparam int Aw = $clog2(BufferDepth)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          set_en,
	input  logic [Aw-1:0] set_idx,
	input  logic          set_wait,
	input  logic [6:0]    set_tag,
	input  logic          clr_en,
	input  logic [Aw-1:0] clr_idx,
	input  logic [6:0]    srch_tag,
	input  logic [Aw-1:0] head,
	output logic          hit,
	output logic [Aw-1:0] hit_idx,
	output logic [BufferDepth-1:0] waiting
);
	logic [6:0] tag_q [BufferDepth];
	logic [BufferDepth-1:0] wait_q;
	logic [BufferDepth-1:0] m;
	logic [BufferDepth-1:0] rot;
	logic [Aw-1:0] off;
	logic [Aw:0] sum;
	assign waiting = wait_q;
	always_comb begin
		int j;
		for (int i = 0; i < BufferDepth; i++) m[i] = wait_q[i] && (tag_q[i] == srch_tag);
		for (int i = 0; i < BufferDepth; i++) begin
			j = i + int'(head);
			if (j >= BufferDepth) j = j - BufferDepth;
			rot[i] = m[j];
		end
		hit = |rot;
		off = '0;
		for (int i = BufferDepth - 1; i >= 0; i--) if (rot[i]) off = Aw'(i);
		sum = {1'b0, head} + {1'b0, off};
		hit_idx = (sum >= (Aw+1)'(BufferDepth)) ? Aw'(sum - (Aw+1)'(BufferDepth)) : sum[Aw-1:0];
	end
	always_ff @(posedge clk) if (set_en) tag_q[set_idx] <= set_tag;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q <= '0;
		end else begin
			if (clr_en) wait_q[clr_idx] <= 1'b0;
			if (set_en) wait_q[set_idx] <= set_wait;
		end
	end
endmodule
